[rtl/drm_pkg.sv]
// shared widths, constants and codes for the distance rolloff pipeline
// no dependencies
package drm_pkg;

   localparam int VOL_W      = 15;
   localparam int SQ_IN_W    = 32;
   localparam int ROOT_W     = 16;
   localparam int SQRT_STEPS = 16;
   localparam int NUM_W      = 47;
   localparam int Q_W        = 31;
   localparam int DB1_W      = 32;
   localparam int LOG_EW     = 6;
   localparam int LOG_FW     = 16;
   localparam int LOG_VW     = LOG_EW + LOG_FW;
   localparam int FRAC_STEPS = 16;
   localparam int DB_W       = 36;
   localparam int SUM_W      = 56;
   localparam int DELTA_W    = SUM_W - 30;

   localparam logic [25:0] LOG_K = 26'd39456604;
   localparam logic signed [DB_W-1:0] DB3_SAT = -36'sd6553600000;

   typedef enum logic [1:0] {
      ZONE_NEAR = 2'd0,
      ZONE_SPAN = 2'd1,
      ZONE_FAR  = 2'd2
   } zone_type;

   typedef enum logic [2:0] {
      CSR_FLOOR   = 3'd0,
      CSR_CEILING = 3'd1,
      CSR_ALPHA   = 3'd2,
      CSR_NEAR    = 3'd3,
      CSR_FAR     = 3'd4
   } csr_index_type;

endpackage

[rtl/drm_isqrt.sv]
// pipelined integer square root, one result bit per stage
// depends on drm_pkg
module drm_isqrt #(
   parameter int SIDE_W = 17
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [drm_pkg::SQ_IN_W-1:0] in_x,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [drm_pkg::ROOT_W-1:0]  out_root,
   output logic [SIDE_W-1:0]           out_side
);
   import drm_pkg::*;

   logic              v_ff   [SQRT_STEPS];
   logic [31:0]       x_ff   [SQRT_STEPS];
   logic [31:0]       res_ff [SQRT_STEPS];
   logic [SIDE_W-1:0] s_ff   [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic              v_src;
      logic [31:0]       x_src;
      logic [31:0]       res_src;
      logic [SIDE_W-1:0] s_src;
      logic [31:0]       bitv;
      logic [32:0]       trial;
      logic [31:0]       x_in;
      logic [31:0]       res_in;

      if (k == 0) begin : g_first
         assign v_src   = in_valid;
         assign x_src   = in_x;
         assign res_src = '0;
         assign s_src   = in_side;
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign x_src   = x_ff[k-1];
         assign res_src = res_ff[k-1];
         assign s_src   = s_ff[k-1];
      end

      assign bitv  = 32'd1 << (30 - 2 * k);
      assign trial = {1'b0, res_src} + {1'b0, bitv};

      always_comb begin
         if ({1'b0, x_src} >= trial) begin
            x_in   = x_src - trial[31:0];
            res_in = (res_src >> 1) + bitv;
         end else begin
            x_in   = x_src;
            res_in = res_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[k]   <= x_in;
            res_ff[k] <= res_in;
            s_ff[k]   <= s_src;
         end
      end
   end

   assign out_valid = v_ff[SQRT_STEPS-1];
   assign out_root  = res_ff[SQRT_STEPS-1][ROOT_W-1:0];
   assign out_side  = s_ff[SQRT_STEPS-1];

endmodule

[rtl/drm_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on drm_pkg
module drm_div #(
   parameter int DW     = 16,
   parameter int SIDE_W = 17
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic [DW-1:0]             span,
   input  logic                      in_valid,
   input  logic [drm_pkg::NUM_W-1:0] in_num,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic [drm_pkg::Q_W-1:0]   out_quot,
   output logic [SIDE_W-1:0]         out_side
);
   import drm_pkg::*;

   logic              v_ff   [Q_W];
   logic [DW-1:0]     rem_ff [Q_W];
   logic [Q_W-1:0]    low_ff [Q_W];
   logic [Q_W-1:0]    q_ff   [Q_W];
   logic [SIDE_W-1:0] s_ff   [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic              v_src;
      logic [DW-1:0]     rem_src;
      logic [Q_W-1:0]    low_src;
      logic [Q_W-1:0]    q_src;
      logic [SIDE_W-1:0] s_src;
      logic [DW:0]       trial;
      logic [DW-1:0]     rem_in;
      logic [Q_W-1:0]    q_in;

      if (k == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = DW'(in_num >> Q_W);
         assign low_src = in_num[Q_W-1:0];
         assign q_src   = '0;
         assign s_src   = in_side;
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign low_src = low_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign s_src   = s_ff[k-1];
      end

      assign trial = {rem_src, low_src[Q_W-1]};

      always_comb begin
         if (trial >= {1'b0, span}) begin
            rem_in = DW'(trial - {1'b0, span});
            q_in   = {q_src[Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            q_in   = {q_src[Q_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= low_src << 1;
            q_ff[k]   <= q_in;
            s_ff[k]   <= s_src;
         end
      end
   end

   assign out_valid = v_ff[Q_W-1];
   assign out_quot  = q_ff[Q_W-1];
   assign out_side  = s_ff[Q_W-1];

endmodule

[rtl/drm_log2.sv]
// two-lane pipelined q16 log2, one fraction bit per squaring stage
// depends on drm_pkg
module drm_log2 #(
   parameter int IN_W   = 30,
   parameter int SIDE_W = 49
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [IN_W-1:0]            in_num,
   input  logic [IN_W-1:0]            in_den,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [drm_pkg::LOG_VW-1:0] out_log_num,
   output logic [drm_pkg::LOG_VW-1:0] out_log_den,
   output logic [SIDE_W-1:0]          out_side
);
   import drm_pkg::*;

   localparam int XW = (IN_W > 32) ? IN_W : 32;
   localparam logic [LOG_EW-1:0] TOPBIT = LOG_EW'(XW - 1);

   logic [IN_W-1:0]   x_src [2];
   logic              vn_ff;
   logic [SIDE_W-1:0] sn_ff;
   logic [LOG_EW-1:0] en_ff [2];
   logic [31:0]       mn_ff [2];

   logic              v_ff [FRAC_STEPS];
   logic [SIDE_W-1:0] s_ff [FRAC_STEPS];
   logic [LOG_EW-1:0] e_ff [2][FRAC_STEPS];
   logic [31:0]       m_ff [2][FRAC_STEPS];
   logic [LOG_FW-1:0] f_ff [2][FRAC_STEPS];

   assign x_src[0] = in_num;
   assign x_src[1] = in_den;

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
      end else if (adv) begin
         vn_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sn_ff <= in_side;
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_norm
      logic [LOG_EW-1:0] e_in;
      logic [XW-1:0]     shifted;

      always_comb begin
         e_in = '0;
         for (int i = 0; i < IN_W; i++) begin
            if (x_src[l][i]) begin
               e_in = LOG_EW'(i);
            end
         end
      end

      assign shifted = XW'(x_src[l]) << (TOPBIT - e_in);

      always_ff @(posedge clock) begin
         if (adv) begin
            en_ff[l] <= e_in;
            mn_ff[l] <= shifted[XW-1 -: 32];
         end
      end
   end

   for (genvar k = 0; k < FRAC_STEPS; k++) begin : g_step
      logic              v_src;
      logic [SIDE_W-1:0] s_src;

      if (k == 0) begin : g_first
         assign v_src = vn_ff;
         assign s_src = sn_ff;
      end else begin : g_next
         assign v_src = v_ff[k-1];
         assign s_src = s_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            s_ff[k] <= s_src;
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [LOG_EW-1:0] e_src;
         logic [31:0]       m_src;
         logic [LOG_FW-1:0] f_src;
         logic [63:0]       square;
         logic [32:0]       top;
         logic [31:0]       m_in;
         logic [LOG_FW-1:0] f_in;

         if (k == 0) begin : g_first
            assign e_src = en_ff[l];
            assign m_src = mn_ff[l];
            assign f_src = '0;
         end else begin : g_next
            assign e_src = e_ff[l][k-1];
            assign m_src = m_ff[l][k-1];
            assign f_src = f_ff[l][k-1];
         end

         assign square = m_src * m_src;
         assign top    = square[63:31];

         always_comb begin
            if (top[32]) begin
               m_in = top[32:1];
               f_in = {f_src[LOG_FW-2:0], 1'b1};
            end else begin
               m_in = top[31:0];
               f_in = {f_src[LOG_FW-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               e_ff[l][k] <= e_src;
               m_ff[l][k] <= m_in;
               f_ff[l][k] <= f_in;
            end
         end
      end
   end

   assign out_valid   = v_ff[FRAC_STEPS-1];
   assign out_side    = s_ff[FRAC_STEPS-1];
   assign out_log_num = {e_ff[0][FRAC_STEPS-1], f_ff[0][FRAC_STEPS-1]};
   assign out_log_den = {e_ff[1][FRAC_STEPS-1], f_ff[1][FRAC_STEPS-1]};

endmodule

[rtl/distance_rolloff_millibel_top.sv]
// distance rolloff in millibels: register file, zone test, blend and clamp stages
// depends on drm_pkg, drm_isqrt, drm_div, drm_log2
//
//   channel  | ports                              | payload
//   req      | req_tvalid req_tready req_tdata    | volume_mb, dist_squared
//   rsp      | rsp_tvalid rsp_tready rsp_tdata    | out_mb, zone
//   csr      | csr_wr_en csr_index csr_wdata      | register writes, no read-back
//
// one transfer accepted per cycle while the pipeline is not held, 71 register stages
// most of those stages are the square root (16 stages), divider (31) and log2 (17)
// synchronous active-high reset clears valid bits and loads register defaults
// the whole pipeline holds while rsp_tvalid is high and rsp_tready is low
module distance_rolloff_millibel_top #(
   parameter int DIST_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // volume_mb[14:0], dist_squared[46:15]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_mb[14:0], zone[16:15]
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import drm_pkg::*;

   localparam int DW     = DIST_WIDTH;
   localparam int LOG_W  = DW + 14;
   localparam int SQ_W   = (2 * DW > 32) ? 2 * DW : 32;
   localparam int SIDE0  = 2 + VOL_W;
   localparam int SIDE1  = SIDE0 + 2 * LOG_W;
   localparam int SIDE2  = SIDE0 + DB1_W;
   localparam logic [DW-1:0]   NEAR_RST    = DW'(256);
   localparam logic [DW-1:0]   FAR_RST     = DW'(25600);
   localparam logic [2*DW-1:0] NEAR_SQ_RST = NEAR_RST * NEAR_RST;
   localparam logic [2*DW-1:0] FAR_SQ_RST  = FAR_RST * FAR_RST;

   logic                     adv;
   logic signed [VOL_W-1:0]  floor_ff;
   logic signed [VOL_W-1:0]  ceiling_ff;
   logic signed [15:0]       alpha_ff;
   logic [15:0]              near_ff;
   logic [15:0]              far_ff;
   logic [31:0]              near_x;
   logic [31:0]              far_x;
   logic [DW-1:0]            near_v;
   logic [DW-1:0]            far_v;
   logic [DW-1:0]            span;
   logic [2*DW-1:0]          near_sq;
   logic [2*DW-1:0]          far_sq;
   logic [SQ_W-1:0]          near_sq_ff;
   logic [SQ_W-1:0]          far_sq_ff;
   logic                     a_neg;
   logic [16:0]              a_abs;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= -15'sd10000;
         ceiling_ff <= '0;
         alpha_ff   <= '0;
         near_ff    <= 16'd256;
         far_ff     <= 16'd25600;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FLOOR:   floor_ff   <= csr_wdata[VOL_W-1:0];
            CSR_CEILING: ceiling_ff <= csr_wdata[VOL_W-1:0];
            CSR_ALPHA:   alpha_ff   <= csr_wdata;
            CSR_NEAR:    near_ff    <= csr_wdata;
            CSR_FAR:     far_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign near_x  = {16'd0, near_ff};
   assign far_x   = {16'd0, far_ff};
   assign near_v  = near_x[DW-1:0];
   assign far_v   = far_x[DW-1:0];
   assign span    = far_v - near_v;
   assign near_sq = near_v * near_v;
   assign far_sq  = far_v * far_v;
   assign a_neg   = alpha_ff[15];
   assign a_abs   = a_neg ? 17'(-{alpha_ff[15], alpha_ff}) : {1'b0, alpha_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         near_sq_ff <= SQ_W'(NEAR_SQ_RST);
         far_sq_ff  <= SQ_W'(FAR_SQ_RST);
      end else begin
         near_sq_ff <= SQ_W'(near_sq);
         far_sq_ff  <= SQ_W'(far_sq);
      end
   end

   // stage 0: input register and zone test
   logic                    v0_ff;
   logic [VOL_W-1:0]        vol0_ff;
   logic [SQ_IN_W-1:0]      sq0_ff;
   zone_type                zone0_ff;
   logic [SQ_W-1:0]         sq_req;
   zone_type                zone_in;

   assign sq_req = SQ_W'(req_tdata[46:15]);

   always_comb begin
      if (sq_req < near_sq_ff) begin
         zone_in = ZONE_NEAR;
      end else if (sq_req > far_sq_ff) begin
         zone_in = ZONE_FAR;
      end else begin
         zone_in = ZONE_SPAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vol0_ff  <= req_tdata[VOL_W-1:0];
         sq0_ff   <= req_tdata[46:15];
         zone0_ff <= zone_in;
      end
   end

   // square root
   logic               sr_valid;
   logic [ROOT_W-1:0]  sr_root;
   logic [SIDE0-1:0]   sr_side;

   drm_isqrt #(.SIDE_W(SIDE0)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v0_ff),
      .in_x      (sq0_ff),
      .in_side   ({zone0_ff, vol0_ff}),
      .out_valid (sr_valid),
      .out_root  (sr_root),
      .out_side  (sr_side)
   );

   // stage 1: dividend and log operands
   logic [31:0]        d32;
   logic [31:0]        dmn32;
   logic [31:0]        fmd32;
   logic [ROOT_W-1:0]  dmn;
   logic [DW-1:0]      fmd;
   logic [15:0]        fl16;
   logic [VOL_W-1:0]   fl_mag;
   logic [30:0]        num_prod;
   logic [LOG_W-1:0]   fmd_prod;
   logic [LOG_W-1:0]   span_prod;
   logic [LOG_W-1:0]   lnum_in;
   logic [LOG_W-1:0]   lden_in;
   logic               v1_ff;
   logic [SIDE0-1:0]   s1_ff;
   logic [NUM_W-1:0]   num1_ff;
   logic [LOG_W-1:0]   lnum1_ff;
   logic [LOG_W-1:0]   lden1_ff;

   assign d32       = 32'(sr_root);
   assign dmn32     = d32 - near_x;
   assign fmd32     = far_x - d32;
   assign dmn       = dmn32[ROOT_W-1:0];
   assign fmd       = fmd32[DW-1:0];
   assign fl16      = 16'(floor_ff);
   assign fl_mag    = floor_ff[VOL_W-1] ? VOL_W'(-fl16) : VOL_W'(fl16);
   assign num_prod  = fl_mag * dmn;
   assign fmd_prod  = 14'd9999 * fmd;
   assign span_prod = 14'd10000 * span;

   always_comb begin
      if (a_neg) begin
         lnum_in = LOG_W'(near_v);
         lden_in = LOG_W'(sr_root);
      end else begin
         lnum_in = LOG_W'(span) + fmd_prod;
         lden_in = span_prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= sr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= sr_side;
         num1_ff  <= {num_prod, 16'd0};
         lnum1_ff <= lnum_in;
         lden1_ff <= lden_in;
      end
   end

   // linear drop division
   logic              dv_valid;
   logic [Q_W-1:0]    dv_quot;
   logic [SIDE1-1:0]  dv_side;
   logic signed [DB1_W-1:0] db1;

   drm_div #(.DW(DW), .SIDE_W(SIDE1)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .span      (span),
      .in_valid  (v1_ff),
      .in_num    (num1_ff),
      .in_side   ({lnum1_ff, lden1_ff, s1_ff}),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   assign db1 = floor_ff[VOL_W-1] ? -DB1_W'(dv_quot) : DB1_W'(dv_quot);

   // log2 of both ratio terms
   logic              lg_valid;
   logic [LOG_VW-1:0] lg_num;
   logic [LOG_VW-1:0] lg_den;
   logic [SIDE2-1:0]  lg_side;

   drm_log2 #(.IN_W(LOG_W), .SIDE_W(SIDE2)) u_log2 (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (dv_valid),
      .in_num      (dv_side[SIDE1-1 -: LOG_W]),
      .in_den      (dv_side[SIDE0 +: LOG_W]),
      .in_side     ({db1, dv_side[SIDE0-1:0]}),
      .out_valid   (lg_valid),
      .out_log_num (lg_num),
      .out_log_den (lg_den),
      .out_side    (lg_side)
   );

   // stage t1: log difference magnitude
   logic signed [LOG_VW:0] diff;
   logic                   t1_v_ff;
   logic [SIDE2-1:0]       t1_s_ff;
   logic                   t1_neg_ff;
   logic [LOG_VW-1:0]      t1_mag_ff;

   assign diff = $signed({1'b0, lg_num}) - $signed({1'b0, lg_den});

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
      end else if (adv) begin
         t1_v_ff <= lg_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_s_ff   <= lg_side;
         t1_neg_ff <= diff[LOG_VW];
         t1_mag_ff <= diff[LOG_VW] ? LOG_VW'(-diff) : LOG_VW'(diff);
      end
   end

   // stage t2: scale to millibels
   logic              t2_v_ff;
   logic [SIDE2-1:0]  t2_s_ff;
   logic              t2_neg_ff;
   logic [47:0]       t2_prod_ff;
   logic [47:0]       prod_in;

   assign prod_in = t1_mag_ff * LOG_K;

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_v_ff <= 1'b0;
      end else if (adv) begin
         t2_v_ff <= t1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t2_s_ff    <= t1_s_ff;
         t2_neg_ff  <= t1_neg_ff;
         t2_prod_ff <= prod_in;
      end
   end

   // stage t3: blend products
   logic signed [DB_W-1:0]  dbr;
   logic signed [DB_W-1:0]  dbx;
   logic signed [17:0]      coef1;
   logic signed [17:0]      coef2;
   logic signed [DB1_W-1:0] t2_db1;
   logic signed [SUM_W-1:0] p1_in;
   logic signed [SUM_W-1:0] p2_in;
   logic                    t3_v_ff;
   logic [SIDE0-1:0]        t3_s_ff;
   logic signed [SUM_W-1:0] t3_p1_ff;
   logic signed [SUM_W-1:0] t3_p2_ff;

   assign dbr    = t2_neg_ff ? -$signed(DB_W'(t2_prod_ff[47:16]))
                             : $signed(DB_W'(t2_prod_ff[47:16]));
   assign dbx    = (a_neg && near_v == '0) ? DB3_SAT : dbr;
   assign coef2  = $signed({1'b0, a_abs});
   assign coef1  = 18'sd16384 - coef2;
   assign t2_db1 = t2_s_ff[SIDE2-1 -: DB1_W];
   assign p1_in  = coef1 * t2_db1;
   assign p2_in  = coef2 * dbx;

   always_ff @(posedge clock) begin
      if (reset) begin
         t3_v_ff <= 1'b0;
      end else if (adv) begin
         t3_v_ff <= t2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t3_s_ff  <= t2_s_ff[SIDE0-1:0];
         t3_p1_ff <= p1_in;
         t3_p2_ff <= p2_in;
      end
   end

   // stage t4: sum and truncate toward zero
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   sum_adj;
   logic                      t4_v_ff;
   logic [SIDE0-1:0]          t4_s_ff;
   logic signed [DELTA_W-1:0] t4_delta_ff;

   assign sum     = t3_p1_ff + t3_p2_ff;
   assign sum_adj = sum[SUM_W-1] ? sum + SUM_W'(30'h3FFFFFFF) : sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         t4_v_ff <= 1'b0;
      end else if (adv) begin
         t4_v_ff <= t3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t4_s_ff     <= t3_s_ff;
         t4_delta_ff <= (span == '0) ? '0 : sum_adj[SUM_W-1:30];
      end
   end

   // output stage: add, clamp, zone select
   logic signed [VOL_W-1:0]   vol4;
   zone_type                  zone4;
   logic signed [DELTA_W:0]   res;
   logic signed [VOL_W-1:0]   out_in;
   logic                      rsp_v_ff;
   logic [VOL_W-1:0]          out_ff;
   zone_type                  zone_ff;

   assign vol4  = t4_s_ff[VOL_W-1:0];
   assign zone4 = zone_type'(t4_s_ff[SIDE0-1 -: 2]);
   assign res   = (DELTA_W + 1)'(vol4) + (DELTA_W + 1)'(t4_delta_ff);

   always_comb begin
      case (zone4)
         ZONE_NEAR: out_in = vol4;
         ZONE_FAR:  out_in = floor_ff;
         default: begin
            if (res < (DELTA_W + 1)'(floor_ff)) begin
               out_in = floor_ff;
            end else if (res > (DELTA_W + 1)'(ceiling_ff)) begin
               out_in = ceiling_ff;
            end else begin
               out_in = res[VOL_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= t4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff  <= out_in;
         zone_ff <= zone4;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {7'd0, zone_ff, out_ff};

endmodule
